[hw/rtl/ppba_pkg.sv]
// Shared types and constants for the physical page bitmap allocator.
package ppba_pkg;

  localparam int FRAME_SHIFT = 12;
  localparam int WORD_BITS   = 32;
  localparam int ADDR_W      = 32;
  localparam int COUNT_W     = 13;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT  = 1'b1;

  localparam logic MODE_FIND = 1'b0;
  localparam logic MODE_SET  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_RD,
    ST_SET_WR,
    ST_SCAN,
    ST_RESULT
  } state_t;

endpackage

[hw/rtl/physical_page_bitmap_allocator_unit.sv]
// First-fit page frame bitmap allocator with a word-wide bitmap memory.
//
// After reset the block runs a clearing pass over every bitmap word with in_stall high.
// A find request scans the bitmap memory one 32-bit word per cycle through its single
// read port, and stops at the first word that holds a free frame or at the last managed
// word. A find with no managed frames goes straight to its result. The managed range is
// page_count saturated at MAX_PAGES. One find is in flight at a time. A find also waits
// while an earlier result still sits stalled in the output register. A set request is a
// read-modify-write of one memory word. A set outside the managed range is dropped in the
// cycle it is accepted. The result sits in an output register, so a new request can be
// accepted while a result waits to transfer.
module physical_page_bitmap_allocator_unit #(
  parameter int MAX_PAGES = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ppba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppba_pkg::ADDR_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            mode,
  input  logic [ppba_pkg::ADDR_W-1:0]     page_address,
  input  logic                            page_state,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ppba_pkg::ADDR_W-1:0]     free_address
);

  localparam int WORDS = (MAX_PAGES + 31) / 32;
  localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IDX_W = WA_W + 5;
  localparam int CNT_W = $clog2(MAX_PAGES + 1);

  ppba_pkg::state_t state, state_next;

  logic [ppba_pkg::ADDR_W-1:0]  region_base;
  logic [ppba_pkg::COUNT_W-1:0] page_count;

  logic [ppba_pkg::WORD_BITS-1:0] bitmap_mem [WORDS];
  logic                           mem_we;
  logic [WA_W-1:0]                mem_waddr;
  logic [ppba_pkg::WORD_BITS-1:0] mem_wdata;
  logic [WA_W-1:0]                mem_raddr;
  logic [ppba_pkg::WORD_BITS-1:0] mem_rdata;

  logic [WA_W-1:0]  clr_ptr;
  logic [WA_W-1:0]  rd_ptr;
  logic [WA_W-1:0]  chk_ptr;
  logic             issue_done;
  logic             data_vld;
  logic [WA_W-1:0]  last_q;
  logic [4:0]       tail_q;
  logic [IDX_W-1:0] idx_q;
  logic             st_q;
  logic [IDX_W-1:0] res_idx_q;
  logic             res_none_q;

  logic [CNT_W-1:0]               managed;
  logic [ppba_pkg::ADDR_W-1:0]    managed_m1;
  logic [ppba_pkg::ADDR_W-1:0]    addr_diff;
  logic [ppba_pkg::ADDR_W-13:0]   set_index;
  logic                           in_range;
  logic                           in_acc;
  logic                           out_free;
  logic                           issue;
  logic [ppba_pkg::WORD_BITS-1:0] tail_mask;
  logic [ppba_pkg::WORD_BITS-1:0] free_bits;
  logic [4:0]                     first_pos;
  logic [ppba_pkg::WORD_BITS-1:0] bit_mask;

  always_comb begin
    if (ppba_pkg::ADDR_W'(page_count) >= ppba_pkg::ADDR_W'(MAX_PAGES)) begin
      managed = CNT_W'(MAX_PAGES);
    end else begin
      managed = CNT_W'(page_count);
    end
  end

  assign managed_m1 = ppba_pkg::ADDR_W'(managed) - 32'd1;
  assign addr_diff  = page_address - region_base;
  assign set_index  = addr_diff[ppba_pkg::ADDR_W-1:ppba_pkg::FRAME_SHIFT];
  assign in_range   = ppba_pkg::ADDR_W'(set_index) < ppba_pkg::ADDR_W'(managed);
  assign in_stall   = (state != ppba_pkg::ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign bit_mask   = 32'd1 << idx_q[4:0];

  always_comb begin
    for (int b = 0; b < ppba_pkg::WORD_BITS; b++) begin
      tail_mask[b] = (5'(b) <= tail_q);
    end
    free_bits = ~mem_rdata & ((chk_ptr == last_q) ? tail_mask : '1);
    first_pos = '0;
    for (int b = ppba_pkg::WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        first_pos = 5'(b);
      end
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = clr_ptr;
    mem_wdata  = '0;
    mem_raddr  = rd_ptr;
    issue      = 1'b0;
    unique case (state)
      ppba_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_ptr == WA_W'(WORDS - 1)) begin
          state_next = ppba_pkg::ST_IDLE;
        end
      end
      ppba_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (mode == ppba_pkg::MODE_SET) begin
            state_next = in_range ? ppba_pkg::ST_SET_RD : ppba_pkg::ST_IDLE;
          end else begin
            state_next = (managed == '0) ? ppba_pkg::ST_RESULT : ppba_pkg::ST_SCAN;
          end
        end
      end
      ppba_pkg::ST_SET_RD: begin
        mem_raddr  = idx_q[IDX_W-1:5];
        state_next = ppba_pkg::ST_SET_WR;
      end
      ppba_pkg::ST_SET_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = idx_q[IDX_W-1:5];
        mem_wdata  = st_q ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);
        state_next = ppba_pkg::ST_IDLE;
      end
      ppba_pkg::ST_SCAN: begin
        issue = !issue_done;
        if (data_vld && ((|free_bits) || (chk_ptr == last_q))) begin
          state_next = ppba_pkg::ST_RESULT;
        end
      end
      ppba_pkg::ST_RESULT: begin
        if (out_free) begin
          state_next = ppba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ppba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= bitmap_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ppba_pkg::ST_CLEAR;
      clr_ptr     <= '0;
      out_valid   <= 1'b0;
      data_vld    <= 1'b0;
      issue_done  <= 1'b0;
      region_base <= '0;
      page_count  <= '0;
    end else begin
      state <= state_next;
      if (state == ppba_pkg::ST_CLEAR) begin
        clr_ptr <= clr_ptr + 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          ppba_pkg::REG_REGION_BASE: region_base <= cfg_data;
          ppba_pkg::REG_PAGE_COUNT:  page_count  <= cfg_data[ppba_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
      data_vld <= issue && (state_next == ppba_pkg::ST_SCAN);
      if (in_acc && mode == ppba_pkg::MODE_FIND) begin
        issue_done <= 1'b0;
      end else if (issue && rd_ptr == last_q) begin
        issue_done <= 1'b1;
      end
      if (state == ppba_pkg::ST_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_ptr <= rd_ptr + 1'b1;
    end
    if (state == ppba_pkg::ST_SCAN && data_vld) begin
      chk_ptr <= chk_ptr + 1'b1;
      if (|free_bits) begin
        res_none_q <= 1'b0;
        res_idx_q  <= {chk_ptr, first_pos};
      end
    end
    if (in_acc) begin
      if (mode == ppba_pkg::MODE_SET) begin
        idx_q <= set_index[IDX_W-1:0];
        st_q  <= page_state;
      end else begin
        rd_ptr     <= '0;
        chk_ptr    <= '0;
        last_q     <= managed_m1[IDX_W-1:5];
        tail_q     <= managed_m1[4:0];
        res_none_q <= 1'b1;
      end
    end
    if (state == ppba_pkg::ST_RESULT && out_free) begin
      free_address <= res_none_q ? '0 :
                      region_base + (ppba_pkg::ADDR_W'(res_idx_q) << ppba_pkg::FRAME_SHIFT);
    end
  end

endmodule

[hw/rtl/ppba_checker.sv]
// Port-level checks for the page bitmap allocator, bound to its top level.
module ppba_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_we,
  input logic [ppba_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [ppba_pkg::ADDR_W-1:0]    cfg_data,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           mode,
  input logic [ppba_pkg::ADDR_W-1:0]    page_address,
  input logic                           page_state,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [ppba_pkg::ADDR_W-1:0]    free_address
);

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input not held off for the clearing pass after reset");

  a_find_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && mode == ppba_pkg::MODE_FIND) |=> in_stall)
    else $error("new transfer taken while a find is in progress");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a find in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(free_address)))
    else $error("stalled result dropped or changed");

endmodule

bind physical_page_bitmap_allocator_unit ppba_checker u_ppba_checker (
  .clk          (clk),
  .rst          (rst),
  .cfg_we       (cfg_we),
  .cfg_index    (cfg_index),
  .cfg_data     (cfg_data),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .mode         (mode),
  .page_address (page_address),
  .page_state   (page_state),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .free_address (free_address)
);

[tb/sv/frame_bitmap_checker.sv]
// Checker for the page bitmap allocator: mirrors the frame bitmap and compares each result.
`timescale 1ns / 1ps

module frame_bitmap_checker #(
  parameter int MAX_PAGES = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ppba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppba_pkg::ADDR_W-1:0]     cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            mode,
  input  logic [ppba_pkg::ADDR_W-1:0]     page_address,
  input  logic                            page_state,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [ppba_pkg::ADDR_W-1:0]     free_address,
  output int                              failures,
  output int                              pending
);

  import ppba_pkg::*;

  logic [ADDR_W-1:0]  region_base_q;
  logic [COUNT_W-1:0] page_count_q;
  bit                 frame_taken [MAX_PAGES];
  logic [ADDR_W-1:0]  expected_free_addr [$];

  initial begin
    failures = 0;
    pending = 0;
  end

  function automatic int unsigned managed_frames();
    int unsigned raw;
    raw = page_count_q;
    return (raw > MAX_PAGES) ? MAX_PAGES : raw;
  endfunction

  function automatic logic [ADDR_W-1:0] predict_first_free();
    int unsigned n;
    n = managed_frames();
    for (int unsigned i = 0; i < n; i++) begin
      if (!frame_taken[i]) return region_base_q + (ADDR_W'(i) << FRAME_SHIFT);
    end
    return '0;
  endfunction

  function automatic void record_frame_state(logic [ADDR_W-1:0] addr, logic state);
    logic [ADDR_W-1:0] frame_index;
    frame_index = (addr - region_base_q) >> FRAME_SHIFT;
    if (frame_index < managed_frames()) frame_taken[frame_index] = state;
  endfunction

  always @(posedge clk) begin : watch_transfers
    logic [ADDR_W-1:0] want;
    if (rst) begin
      foreach (frame_taken[i]) frame_taken[i] = 1'b0;
      region_base_q = '0;
      page_count_q = '0;
      expected_free_addr.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_free_addr.size() == 0) begin
          if (failures < 10)
            $display("free_address %h transferred with no find outstanding", free_address);
          failures++;
        end else begin
          want = expected_free_addr.pop_front();
          if (free_address !== want) begin
            if (failures < 10)
              $display("free_address mismatch: expected %h, got %h", want, free_address);
            failures++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (mode == MODE_FIND) expected_free_addr.push_back(predict_first_free());
        else record_frame_state(page_address, page_state);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_REGION_BASE: region_base_q = cfg_data;
          REG_PAGE_COUNT:  page_count_q = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_free_addr.size();
  end

endmodule

[tb/sv/physical_page_bitmap_allocator_unit_test.sv]
// Top of the page bitmap allocator testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module physical_page_bitmap_allocator_unit_test;

  import ppba_pkg::*;

  localparam int MAX_PAGES     = 4096;
  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 mode;
  logic [ADDR_W-1:0]    page_address;
  logic                 page_state;
  logic                 out_valid;
  logic                 out_stall;
  logic [ADDR_W-1:0]    free_address;
  int                   failures;
  int                   pending;
  int                   idle_cycles = 0;
  bit                   hold_request = 1'b0;
  bit                   sender_calm = 1'b0;

  always #6 clk = ~clk;

  physical_page_bitmap_allocator_unit #(.MAX_PAGES(MAX_PAGES)) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .page_address(page_address), .page_state(page_state),
    .out_valid(out_valid), .out_stall(out_stall), .free_address(free_address)
  );

  frame_bitmap_checker #(.MAX_PAGES(MAX_PAGES)) bitmap_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .page_address(page_address), .page_state(page_state),
    .out_valid(out_valid), .out_stall(out_stall), .free_address(free_address),
    .failures(failures), .pending(pending)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [ADDR_W-1:0] frame_addr(logic [ADDR_W-1:0] base, int unsigned frame);
    return base + (ADDR_W'(frame) << FRAME_SHIFT);
  endfunction

  task automatic send_request(input logic req_mode, input logic [ADDR_W-1:0] addr,
                              input logic state);
    int gap;
    if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
    gap = sender_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= req_mode;
    page_address <= addr;
    page_state <= state;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic find_free();
    send_request(MODE_FIND, $urandom(), 1'($urandom()));
  endtask

  // drain, let trailing set transfers retire, then program both registers
  task automatic settle_and_configure(input logic [ADDR_W-1:0] base,
                                      input logic [COUNT_W-1:0] count);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_REGION_BASE;
    cfg_data <= base;
    @(posedge clk);
    cfg_index <= REG_PAGE_COUNT;
    cfg_data <= ADDR_W'(count);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [ADDR_W-1:0] base, input logic [COUNT_W-1:0] count,
                           input int items, input bit with_hold);
    int unsigned span;
    int unsigned frame;
    int unsigned pick;
    span = count;
    settle_and_configure(base, count);
    if (span > 0 && span <= 64) begin
      for (int unsigned f = 0; f < span; f++) send_request(MODE_SET, frame_addr(base, f), 1'b1);
      find_free();
      send_request(MODE_SET, frame_addr(base, $urandom_range(0, span - 1)), 1'b0);
      find_free();
    end
    if (with_hold) hold_request = 1'b1;
    repeat (items) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        find_free();
      end else if (pick < 85) begin
        if (span == 0) frame = $urandom_range(0, 3);
        else if ($urandom_range(0, 1) == 0) frame = $urandom_range(0, (span > 8) ? 7 : span - 1);
        else frame = $urandom_range(0, span - 1);
        send_request(MODE_SET, frame_addr(base, frame) + $urandom_range(0, 4095),
                     $urandom_range(0, 9) < 7);
      end else if (pick < 90) begin
        send_request(MODE_SET, frame_addr(base, span), 1'($urandom()));
      end else begin
        send_request(MODE_SET, $urandom(), 1'($urandom()));
      end
    end
  endtask

  initial begin : result_receiver
    int wait_cycles;
    bit calm;
    calm = 1'b0;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if ($urandom_range(0, 39) == 0) calm = !calm;
        wait_cycles = calm ? 0 : $urandom_range(0, 10);
        if (wait_cycles > 0) begin
          out_stall <= 1'b1;
          repeat (wait_cycles) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_REGION_BASE;
    cfg_data <= '0;
    in_valid <= 1'b0;
    mode <= MODE_FIND;
    page_address <= '0;
    page_state <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (in_stall);

    settle_and_configure(32'h0000_0000, 13'd0);
    find_free();
    send_request(MODE_SET, 32'h0000_0000, 1'b1);
    find_free();

    settle_and_configure(32'h0000_0000, 13'd3);
    find_free();
    send_request(MODE_SET, 32'h0000_0000, 1'b1);
    send_request(MODE_SET, 32'h0000_1ABC, 1'b1);
    find_free();
    send_request(MODE_SET, 32'h0000_2FFF, 1'b1);
    find_free();
    send_request(MODE_SET, 32'h0000_1000, 1'b0);
    find_free();

    settle_and_configure(32'hFFFF_F000, 13'd8191);
    find_free();
    send_request(MODE_SET, 32'hFFFF_EFFF, 1'b1);
    send_request(MODE_SET, 32'h00FF_EFFF, 1'b1);
    send_request(MODE_SET, 32'h00FF_F000, 1'b1);
    send_request(MODE_SET, 32'h0000_0000, 1'b1);
    find_free();

    settle_and_configure(32'h1234_5ABC, 13'd2);
    find_free();
    send_request(MODE_SET, 32'h1234_6ABB, 1'b1);
    send_request(MODE_SET, 32'h1234_6ABC, 1'b0);
    find_free();

    run_phase(32'h0010_0000, 13'd40, 130, 1'b1);
    run_phase(32'hFFFF_F000, 13'd4096, 40, 1'b0);
    run_phase(32'h1234_5ABC, 13'd33, 110, 1'b0);
    run_phase(32'h0000_0000, 13'd8191, 40, 1'b0);
    run_phase(32'h8000_0000, 13'd1, 50, 1'b0);
    run_phase($urandom() & 32'hFFFF_F000, 13'($urandom_range(2, 64)), 110, 1'b0);
    run_phase($urandom(), 13'($urandom_range(0, 300)), 90, 1'b0);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
